@@ design/hwpma_pkg.sv @@
// Shared constants, types and the lane apply function for the half-word pair
// min-apply block. Used by every module under design/.
package hwpma_pkg;

  // Default slot count of the pairing table
  localparam int PAIR_SLOTS_DEF = 4;

  // Word geometry
  localparam int LANE_W      = 3;
  localparam int WLANE_W     = 4;
  localparam int LANES_WORD  = 16;
  localparam int DATA_W      = 32;
  localparam int WORD_ADDR_W = 31;

  // Opcodes of the input word
  localparam logic OP_LANE = 1'b0;
  localparam logic OP_END  = 1'b1;

  // Result kinds
  localparam logic [1:0] KIND_PROP = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_DROP = 2'd2;

  // Accepted input word as seen by the slot table
  typedef struct packed {
    logic                   upd;
    logic                   end_stream;
    logic                   last;
    logic                   half;
    logic [WORD_ADDR_W-1:0] word;
    logic [WLANE_W-1:0]     wlane;
  } item_t;

  // Outcome of the slot lookup for the current input word
  typedef struct packed {
    logic drop;
    logic complete;
  } lookup_t;

  // Count of zero keeps the old value; otherwise take the unsigned minimum,
  // forced to zero when the two low count bits are zero.
  function automatic logic [DATA_W-1:0] apply_lane(input logic [DATA_W-1:0] old_v,
                                                   input logic [DATA_W-1:0] cand,
                                                   input logic [DATA_W-1:0] cnt);
    logic [DATA_W-1:0] v;
    v = old_v;
    if (cnt != '0) begin
      v = (old_v < cand) ? old_v : cand;
      if (cnt[1:0] == 2'b00) begin
        v = '0;
      end
    end
    return v;
  endfunction

endpackage

@@ design/hwpma_lane_mem.sv @@
// Lane value memory: one write port, one read port with registered read data.
// Depends on hwpma_pkg for the data width.
module hwpma_lane_mem #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [ADDR_W-1:0]             wr_addr,
  input  logic [hwpma_pkg::DATA_W-1:0]  wr_data,
  input  logic                          rd_en,
  input  logic [ADDR_W-1:0]             rd_addr,
  output logic [hwpma_pkg::DATA_W-1:0]  rd_data
);

  logic [hwpma_pkg::DATA_W-1:0] mem [DEPTH];

  // Write the applied lane value
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read one lane; hold the data while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ design/hwpma_slot_table.sv @@
// Pairing slot table: busy and half-done flags, word tags and per-lane
// written bits. Depends on hwpma_pkg for item_t and lookup_t.
module hwpma_slot_table #(
  parameter int PAIR_SLOTS = hwpma_pkg::PAIR_SLOTS_DEF,
  parameter int SLOT_W     = 2
) (
  input  logic                              clk,
  input  logic                              rst,
  input  hwpma_pkg::item_t                  item,
  output hwpma_pkg::lookup_t                lookup,
  output logic [SLOT_W-1:0]                 slot,
  input  logic [SLOT_W-1:0]                 emit_slot,
  input  logic [hwpma_pkg::WLANE_W-1:0]     emit_lane,
  input  logic                              emit_free,
  output logic [hwpma_pkg::WORD_ADDR_W-1:0] emit_word,
  output logic                              emit_lane_ok
);

  logic                              busy     [PAIR_SLOTS];
  logic                              low_done [PAIR_SLOTS];
  logic                              high_done[PAIR_SLOTS];
  logic [hwpma_pkg::WORD_ADDR_W-1:0] tag      [PAIR_SLOTS];
  logic [hwpma_pkg::LANES_WORD-1:0]  lane_ok  [PAIR_SLOTS];

  logic hit;
  logic free_any;
  logic [SLOT_W-1:0] hit_slot;
  logic [SLOT_W-1:0] free_slot;
  logic new_low;
  logic new_high;

  // Find the first matching busy slot and the first free slot
  always_comb begin
    hit       = 1'b0;
    free_any  = 1'b0;
    hit_slot  = '0;
    free_slot = '0;
    for (int i = 0; i < PAIR_SLOTS; i++) begin
      if (!hit && busy[i] && tag[i] == item.word) begin
        hit      = 1'b1;
        hit_slot = SLOT_W'(i);
      end
      if (!free_any && !busy[i]) begin
        free_any  = 1'b1;
        free_slot = SLOT_W'(i);
      end
    end
  end

  // Merge the half-done flags with this word's last-lane mark
  always_comb begin
    slot            = hit ? hit_slot : free_slot;
    new_low         = (hit && low_done[slot])  || (item.last && !item.half);
    new_high        = (hit && high_done[slot]) || (item.last && item.half);
    lookup.drop     = !hit && !free_any;
    lookup.complete = new_low && new_high && !lookup.drop;
  end

  // Control flags: take, update, free after emission, clear at end of stream
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PAIR_SLOTS; i++) begin
        busy[i]      <= 1'b0;
        low_done[i]  <= 1'b0;
        high_done[i] <= 1'b0;
      end
    end else if (item.end_stream) begin
      for (int i = 0; i < PAIR_SLOTS; i++) begin
        busy[i]      <= 1'b0;
        low_done[i]  <= 1'b0;
        high_done[i] <= 1'b0;
      end
    end else begin
      if (item.upd && !lookup.drop) begin
        busy[slot]      <= 1'b1;
        low_done[slot]  <= new_low;
        high_done[slot] <= new_high;
      end
      if (emit_free) begin
        busy[emit_slot]      <= 1'b0;
        low_done[emit_slot]  <= 1'b0;
        high_done[emit_slot] <= 1'b0;
      end
    end
  end

  // Word tag and lane written bits; a newly taken slot starts with no lanes
  always_ff @(posedge clk) begin
    if (item.upd && !lookup.drop) begin
      tag[slot]     <= item.word;
      lane_ok[slot] <= (hit ? lane_ok[slot] : '0) |
                       (hwpma_pkg::LANES_WORD'(1) << item.wlane);
    end
  end

  assign emit_word    = tag[emit_slot];
  assign emit_lane_ok = lane_ok[emit_slot][emit_lane];

endmodule

@@ design/half_word_pair_min_apply_core.sv @@
// Top level of the half-word pair min-apply block: handshake, emit sequencer
// and output register. Depends on hwpma_pkg, hwpma_slot_table, hwpma_lane_mem.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+---------------------------------------
//   item     | item_valid / item_stall    | opcode half_address lane last_lane
//            |                            | update_distance update_count old_property
//   result   | result_valid / result_stall| kind word_address out_lane new_property
//            |                            | word_last
//
// An item that completes a word is followed by emission of its 16 lanes, one lane
// a cycle while the output register can take it, through the single read port of
// the lane memory; no item is taken during emission. End-of-stream and drop words
// give one result. Reset is synchronous and clears all slot flags; no memory
// clearing pass. A stalled result holds the output register and blocks input.
module half_word_pair_min_apply_core #(
  parameter int PAIR_SLOTS = hwpma_pkg::PAIR_SLOTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  logic                              opcode,
  input  logic [31:0]                       half_address,
  input  logic [hwpma_pkg::LANE_W-1:0]      lane,
  input  logic                              last_lane,
  input  logic [hwpma_pkg::DATA_W-1:0]      update_distance,
  input  logic [hwpma_pkg::DATA_W-1:0]      update_count,
  input  logic [hwpma_pkg::DATA_W-1:0]      old_property,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic [1:0]                        kind,
  output logic [hwpma_pkg::WORD_ADDR_W-1:0] word_address,
  output logic [hwpma_pkg::WLANE_W-1:0]     out_lane,
  output logic [hwpma_pkg::DATA_W-1:0]      new_property,
  output logic                              word_last
);

  localparam int SLOT_W = (PAIR_SLOTS > 1) ? $clog2(PAIR_SLOTS) : 1;
  localparam int ADDR_W = SLOT_W + hwpma_pkg::WLANE_W;
  localparam int DEPTH  = PAIR_SLOTS * hwpma_pkg::LANES_WORD;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  localparam logic [hwpma_pkg::WLANE_W-1:0] LAST_LANE_IDX =
    hwpma_pkg::WLANE_W'(hwpma_pkg::LANES_WORD - 1);

  logic state;
  logic state_next;
  logic [SLOT_W-1:0] emit_slot;
  logic [hwpma_pkg::WLANE_W-1:0] emit_cnt;

  hwpma_pkg::item_t   item;
  hwpma_pkg::lookup_t lookup;
  logic [SLOT_W-1:0]  slot;

  logic accept;
  logic upd_valid;
  logic end_valid;
  logic out_free;
  logic emit_issue;
  logic emit_free;
  logic emit_lane_ok;
  logic [hwpma_pkg::WORD_ADDR_W-1:0] emit_word;
  logic [hwpma_pkg::WLANE_W-1:0] wlane;
  logic [hwpma_pkg::DATA_W-1:0] rd_data;
  logic prop_ok;

  // Handshake and decode of the input word
  assign out_free   = !result_valid || !result_stall;
  assign item_stall = (state == ST_EMIT) || !out_free;
  assign accept     = item_valid && !item_stall;
  assign upd_valid  = accept && (opcode == hwpma_pkg::OP_LANE);
  assign end_valid  = accept && (opcode == hwpma_pkg::OP_END);
  assign wlane      = {half_address[0], lane};

  always_comb begin
    item.upd        = upd_valid;
    item.end_stream = end_valid;
    item.last       = last_lane;
    item.half       = half_address[0];
    item.word       = half_address[31:1];
    item.wlane      = wlane;
  end

  hwpma_slot_table #(
    .PAIR_SLOTS (PAIR_SLOTS),
    .SLOT_W     (SLOT_W)
  ) u_slot_table (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .lookup       (lookup),
    .slot         (slot),
    .emit_slot    (emit_slot),
    .emit_lane    (emit_cnt),
    .emit_free    (emit_free),
    .emit_word    (emit_word),
    .emit_lane_ok (emit_lane_ok)
  );

  // Emit one lane a cycle whenever the output register can take it
  assign emit_issue = (state == ST_EMIT) && out_free;
  assign emit_free  = emit_issue && (emit_cnt == LAST_LANE_IDX);

  hwpma_lane_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_lane_mem (
    .clk     (clk),
    .wr_en   (upd_valid && !lookup.drop),
    .wr_addr ({slot, wlane}),
    .wr_data (hwpma_pkg::apply_lane(old_property, update_distance, update_count)),
    .rd_en   (emit_issue),
    .rd_addr ({emit_slot, emit_cnt}),
    .rd_data (rd_data)
  );

  // Sequencer: enter emission on a completing word, leave after lane 15
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (upd_valid && lookup.complete) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      emit_slot <= slot;
      emit_cnt  <= '0;
    end else if (emit_issue) begin
      emit_cnt <= emit_cnt + 1'b1;
    end
  end

  // Output word valid: set on load, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit_issue || end_valid || (upd_valid && lookup.drop)) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // Output word payload
  always_ff @(posedge clk) begin
    if (emit_issue) begin
      kind         <= hwpma_pkg::KIND_PROP;
      word_address <= emit_word;
      out_lane     <= emit_cnt;
      word_last    <= (emit_cnt == LAST_LANE_IDX);
      prop_ok      <= emit_lane_ok;
    end else if (end_valid) begin
      kind         <= hwpma_pkg::KIND_END;
      word_address <= '0;
      out_lane     <= '0;
      word_last    <= 1'b1;
      prop_ok      <= 1'b0;
    end else if (upd_valid && lookup.drop) begin
      kind         <= hwpma_pkg::KIND_DROP;
      word_address <= half_address[31:1];
      out_lane     <= wlane;
      word_last    <= 1'b0;
      prop_ok      <= 1'b0;
    end
  end

  // Lanes never written since the slot was taken read as zero
  assign new_property = prop_ok ? rd_data : '0;

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for half_word_pair_min_apply_core: directed and random lane
// words pass through a slot-table predictor and every result is checked field by field.
// Depends on hwpma_pkg and the half_word_pair_min_apply_core design.
module testbench;
  import hwpma_pkg::*;

  localparam int SLOTS        = PAIR_SLOTS_DEF;
  localparam int LANES_HALF   = 8;
  localparam int ITEM_GOAL    = 460;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 40;
  localparam int IDLE_PCT     = 12;

  typedef struct packed {
    logic              pause;
    logic              opcode;
    logic [31:0]       half_address;
    logic [LANE_W-1:0] lane;
    logic              last_lane;
    logic [DATA_W-1:0] distance;
    logic [DATA_W-1:0] count;
    logic [DATA_W-1:0] old_value;
  } lane_word_t;

  typedef struct packed {
    logic [1:0]             kind;
    logic [WORD_ADDR_W-1:0] word;
    logic [WLANE_W-1:0]     lane;
    logic [DATA_W-1:0]      value;
    logic                   last;
  } lane_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   item_valid = 1'b0;
  logic                   item_stall;
  logic                   opcode = OP_LANE;
  logic [31:0]            half_address = '0;
  logic [LANE_W-1:0]      lane = '0;
  logic                   last_lane = 1'b0;
  logic [DATA_W-1:0]      update_distance = '0;
  logic [DATA_W-1:0]      update_count = '0;
  logic [DATA_W-1:0]      old_property = '0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  logic [1:0]             kind;
  logic [WORD_ADDR_W-1:0] word_address;
  logic [WLANE_W-1:0]     out_lane;
  logic [DATA_W-1:0]      new_property;
  logic                   word_last;

  lane_word_t   pending_words[$];
  lane_result_t expected_lanes[$];
  int           stimulus_count = 0;
  int           words_accepted = 0;
  int           mismatch_count = 0;
  int           cycle_count = 0;
  logic         item_taken = 1'b0;
  logic         quiet;

  // Pairing table as the predictor sees it
  bit                     pair_busy [SLOTS];
  logic [WORD_ADDR_W-1:0] pair_word [SLOTS];
  bit                     low_done [SLOTS];
  bit                     high_done [SLOTS];
  logic [DATA_W-1:0]      pair_lanes [SLOTS][LANES_WORD];

  half_word_pair_min_apply_core #(
    .PAIR_SLOTS(SLOTS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .opcode(opcode),
    .half_address(half_address),
    .lane(lane),
    .last_lane(last_lane),
    .update_distance(update_distance),
    .update_count(update_count),
    .old_property(old_property),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .kind(kind),
    .word_address(word_address),
    .out_lane(out_lane),
    .new_property(new_property),
    .word_last(word_last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // No idling on either side through this stretch of the run
  assign quiet = (words_accepted >= 200) && (words_accepted < 320);

  task automatic queue_lane_word(input logic op, input logic [31:0] haddr,
                                 input logic [LANE_W-1:0] ln, input logic lst,
                                 input logic [DATA_W-1:0] upd_dist,
                                 input logic [DATA_W-1:0] cnt,
                                 input logic [DATA_W-1:0] old_v);
    lane_word_t w;
    w.pause = 1'b0;
    w.opcode = op;
    w.half_address = haddr;
    w.lane = ln;
    w.last_lane = lst;
    w.distance = upd_dist;
    w.count = cnt;
    w.old_value = old_v;
    pending_words.push_back(w);
    stimulus_count++;
  endtask

  // Hold the sender until every expected result is out
  task automatic queue_pause();
    lane_word_t w;
    w = '0;
    w.pause = 1'b1;
    pending_words.push_back(w);
  endtask

  function automatic logic [DATA_W-1:0] random_value();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] random_count();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return $urandom & 32'hFFFF_FFFC;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_result(input logic [1:0] k, input logic [WORD_ADDR_W-1:0] wa,
                             input logic [WLANE_W-1:0] wl, input logic [DATA_W-1:0] v,
                             input logic lst);
    lane_result_t r;
    r.kind = k;
    r.word = wa;
    r.lane = wl;
    r.value = v;
    r.last = lst;
    expected_lanes.push_back(r);
  endtask

  // Advance the pairing table by one accepted word and queue what it emits
  task automatic predict_pair_table(input lane_word_t w);
    int slot;
    logic [WORD_ADDR_W-1:0] waddr;
    logic [WLANE_W-1:0] wl;
    logic [DATA_W-1:0] v;
    waddr = w.half_address[31:1];
    wl = {w.half_address[0], w.lane};
    if (w.opcode == OP_END) begin
      for (int i = 0; i < SLOTS; i++) begin
        pair_busy[i] = 1'b0;
        low_done[i] = 1'b0;
        high_done[i] = 1'b0;
      end
      push_result(KIND_END, '0, '0, '0, 1'b1);
      return;
    end
    slot = -1;
    for (int i = 0; i < SLOTS; i++)
      if (slot < 0 && pair_busy[i] && pair_word[i] == waddr) slot = i;
    if (slot < 0) begin
      for (int i = 0; i < SLOTS; i++)
        if (slot < 0 && !pair_busy[i]) slot = i;
      if (slot < 0) begin
        push_result(KIND_DROP, waddr, wl, '0, 1'b0);
        return;
      end
      pair_busy[slot] = 1'b1;
      pair_word[slot] = waddr;
      low_done[slot] = 1'b0;
      high_done[slot] = 1'b0;
      for (int i = 0; i < LANES_WORD; i++) pair_lanes[slot][i] = '0;
    end
    // Unsigned min unless the count is zero; a count with low bits clear forces zero
    v = w.old_value;
    if (w.count != '0) begin
      v = (w.old_value < w.distance) ? w.old_value : w.distance;
      if (w.count[1:0] == 2'b00) v = '0;
    end
    pair_lanes[slot][wl] = v;
    if (w.last_lane) begin
      if (w.half_address[0]) high_done[slot] = 1'b1;
      else low_done[slot] = 1'b1;
    end
    if (low_done[slot] && high_done[slot]) begin
      for (int i = 0; i < LANES_WORD; i++)
        push_result(KIND_PROP, pair_word[slot], WLANE_W'(i), pair_lanes[slot][i],
                    i == LANES_WORD - 1);
      pair_busy[slot] = 1'b0;
      low_done[slot] = 1'b0;
      high_done[slot] = 1'b0;
    end
  endtask

  task automatic build_directed();
    // End marker with every ignored field at ones
    queue_lane_word(OP_END, 32'hFFFF_FFFF, 3'd7, 1'b1, '1, '1, '1);
    // Word 0: keep on zero count, unsigned min, forced zero, overwrite, missing lanes
    queue_lane_word(OP_LANE, {31'd0, 1'b0}, 3'd0, 1'b0, 32'd0, 32'd0, 32'hFFFF_FFFF);
    queue_lane_word(OP_LANE, {31'd0, 1'b1}, 3'd0, 1'b0, 32'd3, 32'd1, 32'd5);
    queue_lane_word(OP_LANE, {31'd0, 1'b0}, 3'd5, 1'b0, 32'hFFFF_FFFF, 32'd2, 32'd7);
    queue_lane_word(OP_LANE, {31'd0, 1'b1}, 3'd3, 1'b0, 32'h10, 32'hFFFF_FFFF, 32'h20);
    queue_lane_word(OP_LANE, {31'd0, 1'b1}, 3'd3, 1'b0, 32'd1, 32'd4, 32'd1);
    queue_lane_word(OP_LANE, {31'd0, 1'b0}, 3'd7, 1'b1, 32'd9, 32'hFFFF_FFFC, 32'd9);
    queue_lane_word(OP_LANE, {31'd0, 1'b1}, 3'd7, 1'b1, 32'h8000_0000, 32'd3,
                    32'hFFFF_FFFF);
    // Top word address, with a second last on a half that is already done
    queue_lane_word(OP_LANE, 32'hFFFF_FFFE, 3'd7, 1'b1, random_value(), 32'd1,
                    random_value());
    queue_lane_word(OP_LANE, 32'hFFFF_FFFE, 3'd2, 1'b1, random_value(), 32'd5,
                    random_value());
    queue_lane_word(OP_LANE, 32'hFFFF_FFFF, 3'd7, 1'b1, random_value(), 32'd6,
                    random_value());
    // Fill every slot, then drop a fifth word
    for (int i = 1; i <= SLOTS; i++)
      queue_lane_word(OP_LANE, {31'(i), 1'b0}, 3'd0, 1'b0, random_value(),
                      random_count(), random_value());
    queue_lane_word(OP_LANE, {31'(SLOTS + 1), 1'b1}, 3'd6, 1'b0, random_value(),
                    random_count(), random_value());
    // Complete word 2 so the dropped word finds a free slot
    queue_lane_word(OP_LANE, {31'd2, 1'b1}, 3'd1, 1'b1, random_value(), 32'd1,
                    random_value());
    queue_lane_word(OP_LANE, {31'd2, 1'b0}, 3'd4, 1'b1, random_value(), 32'd7,
                    random_value());
    queue_lane_word(OP_LANE, {31'(SLOTS + 1), 1'b0}, 3'd0, 1'b0, random_value(),
                    random_count(), random_value());
    queue_pause();
    // End of stream discards open halves; word 1 starts over from a clean slot
    queue_lane_word(OP_END, 32'd0, 3'd0, 1'b0, '0, '0, '0);
    queue_lane_word(OP_LANE, {31'd1, 1'b1}, 3'd7, 1'b1, random_value(), 32'd9,
                    random_value());
    queue_lane_word(OP_LANE, {31'd1, 1'b0}, 3'd0, 1'b1, random_value(), 32'd1,
                    random_value());
    queue_lane_word(OP_END, $urandom, 3'd3, 1'b1, $urandom, $urandom, $urandom);
  endtask

  // Batches of interleaved whole words, with noise and an end marker most of the time
  task automatic build_random();
    logic [WLANE_W-1:0]     lane_seq [5][24];
    bit                     last_seq [5][24];
    int                     seq_len [5];
    int                     seq_pos [5];
    logic [WORD_ADDR_W-1:0] words [5];
    logic [LANE_W-1:0]      low_order [LANES_HALF];
    logic [LANE_W-1:0]      high_order [LANES_HALF];
    logic [LANE_W-1:0]      t;
    int n_words, batch, w, i, j, low_i, high_i, left;
    batch = 0;
    while (stimulus_count < ITEM_GOAL) begin
      n_words = $urandom_range(1, 5);
      for (w = 0; w < n_words; w++) begin
        case ($urandom_range(0, 9))
          0: words[w] = '1;
          1: words[w] = '0;
          default: words[w] = WORD_ADDR_W'($urandom);
        endcase
        for (i = 0; i < LANES_HALF; i++) begin
          low_order[i] = LANE_W'(i);
          high_order[i] = LANE_W'(i);
        end
        for (i = LANES_HALF - 1; i > 0; i--) begin
          j = $urandom_range(0, i);
          t = low_order[i];
          low_order[i] = low_order[j];
          low_order[j] = t;
          j = $urandom_range(0, i);
          t = high_order[i];
          high_order[i] = high_order[j];
          high_order[j] = t;
        end
        // Now and then repeat one lane and leave another out
        if ($urandom_range(0, 5) == 0)
          low_order[$urandom_range(0, 6)] = low_order[$urandom_range(0, 7)];
        if ($urandom_range(0, 5) == 0)
          high_order[$urandom_range(0, 6)] = high_order[$urandom_range(0, 7)];
        low_i = 0;
        high_i = 0;
        seq_len[w] = 0;
        seq_pos[w] = 0;
        while (low_i < LANES_HALF || high_i < LANES_HALF) begin
          if (high_i == LANES_HALF || (low_i < LANES_HALF && $urandom_range(0, 1) == 0)) begin
            lane_seq[w][seq_len[w]] = {1'b0, low_order[low_i]};
            last_seq[w][seq_len[w]] = (low_i == LANES_HALF - 1);
            low_i++;
          end else begin
            lane_seq[w][seq_len[w]] = {1'b1, high_order[high_i]};
            last_seq[w][seq_len[w]] = (high_i == LANES_HALF - 1);
            high_i++;
          end
          seq_len[w]++;
        end
      end
      left = LANES_WORD * n_words;
      while (left > 0) begin
        w = $urandom_range(0, n_words - 1);
        if (seq_pos[w] < seq_len[w]) begin
          if ($urandom_range(0, 15) == 0)
            queue_lane_word(($urandom_range(0, 19) == 0) ? OP_END : OP_LANE,
                            ($urandom_range(0, 3) == 0) ? {words[w], 1'($urandom)}
                                                        : $urandom,
                            LANE_W'($urandom), 1'($urandom), random_value(),
                            random_count(), random_value());
          i = seq_pos[w];
          queue_lane_word(OP_LANE, {words[w], lane_seq[w][i][WLANE_W-1]},
                          lane_seq[w][i][LANE_W-1:0], last_seq[w][i], random_value(),
                          random_count(), random_value());
          seq_pos[w]++;
          left--;
        end
      end
      if ($urandom_range(0, 3) != 0)
        queue_lane_word(OP_END, $urandom, LANE_W'($urandom), 1'($urandom), $urandom,
                        $urandom, $urandom);
      batch++;
      if (batch % 8 == 0) queue_pause();
    end
  endtask

  // Drive input words and result stall at the falling edge
  always @(negedge clk) begin : drive_items
    lane_word_t send;
    if (rst) begin
      item_valid <= 1'b0;
      result_stall <= 1'b0;
    end else begin
      result_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
      if (!item_valid || item_taken) begin
        if (pending_words.size() == 0 || (!quiet && $urandom_range(0, 99) < IDLE_PCT)) begin
          item_valid <= 1'b0;
        end else if (pending_words[0].pause) begin
          item_valid <= 1'b0;
          if (expected_lanes.size() == 0) void'(pending_words.pop_front());
        end else begin
          send = pending_words.pop_front();
          item_valid <= 1'b1;
          opcode <= send.opcode;
          half_address <= send.half_address;
          lane <= send.lane;
          last_lane <= send.last_lane;
          update_distance <= send.distance;
          update_count <= send.count;
          old_property <= send.old_value;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  // Predict on each accepted word, check each accepted result at the rising edge
  always @(posedge clk) begin : watch_ports
    lane_word_t seen;
    lane_result_t want;
    if (rst) begin
      item_taken <= 1'b0;
    end else begin
      item_taken <= item_valid && !item_stall;
      if (item_valid && !item_stall) begin
        seen.pause = 1'b0;
        seen.opcode = opcode;
        seen.half_address = half_address;
        seen.lane = lane;
        seen.last_lane = last_lane;
        seen.distance = update_distance;
        seen.count = update_count;
        seen.old_value = old_property;
        predict_pair_table(seen);
        words_accepted++;
      end
      if (result_valid && !result_stall) begin
        if (expected_lanes.size() == 0) begin
          $error("unexpected result: kind %0d word %0h lane %0d", kind, word_address,
                 out_lane);
          mismatch_count++;
        end else begin
          want = expected_lanes.pop_front();
          check_field("kind", 32'(want.kind), 32'(kind));
          check_field("word_address", 32'(want.word), 32'(word_address));
          check_field("out_lane", 32'(want.lane), 32'(out_lane));
          check_field("new_property", want.value, new_property);
          check_field("word_last", 32'(want.last), 32'(word_last));
        end
      end
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      pair_busy[i] = 1'b0;
      low_done[i] = 1'b0;
      high_done[i] = 1'b0;
    end
    build_directed();
    build_random();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    while (pending_words.size() != 0 || item_valid || expected_lanes.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_lanes.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
